### design/tops_pkg.sv
// ----------------------------------------------------------------------------
// tops_pkg
// Shared constants, types and codes for the bucket tree path store.
// ----------------------------------------------------------------------------
package tops_pkg;

	// Tree geometry and storage sizes
	localparam int MAX_HEIGHT   = 4;
	localparam int SLOTS        = 4;
	localparam int NUM_BLOCKS   = 32;
	localparam int PAYLOAD_BITS = 64;

	localparam int NUM_BUCKETS = (2 << MAX_HEIGHT) - 1;
	localparam int BKT_W       = $clog2(NUM_BUCKETS);
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int BLK_W       = $clog2(NUM_BLOCKS);
	localparam int MAP_W       = MAX_HEIGHT;
	localparam int NODE_W      = MAX_HEIGHT + 1;
	localparam int LVL_W       = $clog2(MAX_HEIGHT + 2);

	// Field widths of the channels
	localparam int CMD_W      = 2;
	localparam int BLK_IN_W   = 5;
	localparam int LEAF_IN_W  = 4;
	localparam int LEVEL_W    = 3;
	localparam int SLOT_IN_W  = 2;
	localparam int PAY_W      = 64;
	localparam int STATUS_W   = 2;
	localparam int HT_W       = 3;

	localparam logic [HT_W-1:0] HEIGHT_RESET = HT_W'(4);

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_LEAF = 2'd0,
		CMD_STORE    = 2'd1,
		CMD_FETCH    = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OCCUPIED  = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_STORE,
		S_FETCH,
		S_DONE
	} state_t;

	// One slot of a bucket as kept in the slot memories
	typedef struct packed {
		logic [BLK_W-1:0]        blk;
		logic [PAYLOAD_BITS-1:0] payload;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	// Control outputs of the sequencer
	typedef struct packed {
		logic req_ready;
		logic store_en;
		logic fetch_rd;
		logic use_lvl_cnt;
	} ctrl_t;

endpackage

### design/tops_ifs.sv
// ----------------------------------------------------------------------------
// tops_ifs
// Valid/ready channels of the path store: request, response, configuration.
// ----------------------------------------------------------------------------
interface tops_req_if;
	logic                             valid;
	logic                             ready;
	logic [tops_pkg::CMD_W-1:0]       cmd;
	logic [tops_pkg::BLK_IN_W-1:0]    block_index;
	logic [tops_pkg::LEAF_IN_W-1:0]   leaf;
	logic [tops_pkg::LEVEL_W-1:0]     level;
	logic [tops_pkg::SLOT_IN_W-1:0]   slot;
	logic [tops_pkg::PAY_W-1:0]       payload;

	modport source (output valid, cmd, block_index, leaf, level, slot, payload, input ready);
	modport sink   (input valid, cmd, block_index, leaf, level, slot, payload, output ready);
endinterface

interface tops_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tops_pkg::STATUS_W-1:0]   status;
	logic [tops_pkg::PAY_W-1:0]      payload_out;

	modport source (output valid, status, payload_out, input ready);
	modport sink   (input valid, status, payload_out, output ready);
endinterface

interface tops_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tops_pkg::HT_W-1:0]   tree_height;

	modport source (output valid, tree_height, input ready);
	modport sink   (input valid, tree_height, output ready);
endinterface

### design/tree_oram_path_store.sv
// ----------------------------------------------------------------------------
// tree_oram_path_store
// Bucket tree of four-slot buckets with a leaf position map: set a block's
// leaf, store a block at a level and slot on its path, fetch a block.
// ----------------------------------------------------------------------------
//
//   channel  role  handshake    carries
//   -------  ----  -----------  ---------------------------------------------
//   cfg      sink  valid/ready  tree_height (always ready)
//   req      sink  valid/ready  cmd, block_index, leaf, level, slot, payload
//   rsp      src   valid/ready  status, payload_out (one item per request)
//
// One request item at a time. A fetch walks its path from root to leaf, up to
// the height in use (at most 4), as the path unit and the slot memories
// visit one bucket a cycle; a hit ends the walk early.
// The result sits in an output register; a stalled rsp holds the sequencer
// in its final state. Reset clears the position map, every slot valid bit
// and the height register (to 4); the slot memories need no clearing.
// ----------------------------------------------------------------------------
module tree_oram_path_store (
	input  logic            clk,
	input  logic            arst_n,
	tops_cfg_if.sink        cfg,
	tops_req_if.sink        req,
	tops_rsp_if.source      rsp
);
	import tops_pkg::*;

	// Configuration and position map
	logic [HT_W-1:0]                   tree_height_q;
	logic [NUM_BLOCKS-1:0][MAP_W-1:0]  pmap_q;
	logic [NUM_BUCKETS-1:0][SLOTS-1:0] valid_q;

	// Latched request
	logic [CMD_W-1:0]        cmd_q;
	logic [BLK_W-1:0]        blk_q;
	logic [HT_W-1:0]         h_q;
	logic [HT_W-1:0]         lv_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// Sequencer
	state_t                  state_q, state_d;
	ctrl_t                   ctrl;
	logic [LVL_W-1:0]        lvl_q;
	logic                    issued_s1;
	logic                    last_s1;
	logic [BKT_W-1:0]        bucket_s1;

	// Result being built and output register
	logic [STATUS_W-1:0]     res_status_q;
	logic [PAY_W-1:0]        res_payload_q;
	logic                    rsp_valid_q;
	logic [STATUS_W-1:0]     rsp_status_q;
	logic [PAY_W-1:0]        rsp_payload_q;

	logic                    req_fire;
	logic                    out_free;
	logic [HT_W-1:0]         h_in;
	logic [HT_W-1:0]         lv_in;
	logic [HT_W-1:0]         unit_level;
	logic [BKT_W-1:0]        bucket;
	logic                    occupied;
	logic                    last_level;
	logic [ENTRY_W-1:0]      rd_word [SLOTS];
	slot_entry_t             wr_entry;
	logic                    hit;
	logic [PAY_W-1:0]        hit_payload;

	assign req_fire = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// Clamp height to the maximum and a store level to the height
	assign h_in  = (tree_height_q > HT_W'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT) : tree_height_q;
	assign lv_in = (req.level > h_in) ? h_in : req.level;

	// Shared path unit: store level while storing, walk counter while fetching
	assign unit_level = ctrl.use_lvl_cnt ? HT_W'(lvl_q) : lv_q;

	tops_path_unit u_path (
		.height (h_q),
		.leaf   (pmap_q[blk_q]),
		.level  (unit_level),
		.bucket (bucket)
	);

	assign occupied   = valid_q[bucket][slot_q];
	assign last_level = (HT_W'(lvl_q) == h_q);
	assign wr_entry   = '{blk: blk_q, payload: pay_q};

	// One memory per slot; a fetch reads all slots of a bucket at once
	for (genvar j = 0; j < SLOTS; j++) begin : g_slot
		tops_ram #(
			.WIDTH (ENTRY_W),
			.DEPTH (NUM_BUCKETS)
		) u_slot_ram (
			.clk   (clk),
			.we    (ctrl.store_en && !occupied && (slot_q == SLOT_W'(j))),
			.waddr (bucket),
			.wdata (wr_entry),
			.raddr (bucket),
			.rdata (rd_word[j])
		);
	end

	// Match in the bucket read last cycle; the highest slot wins
	always_comb begin
		slot_entry_t ent;
		hit         = 1'b0;
		hit_payload = '0;
		for (int j = 0; j < SLOTS; j++) begin
			ent = slot_entry_t'(rd_word[j]);
			if (valid_q[bucket_s1][j] && (ent.blk == blk_q)) begin
				hit         = 1'b1;
				hit_payload = PAY_W'(ent.payload);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (cmd_t'(req.cmd))
						CMD_STORE: state_d = S_STORE;
						CMD_FETCH: state_d = S_FETCH;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_STORE: state_d = S_DONE;
			S_FETCH: begin
				if (issued_s1 && (hit || last_s1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			S_IDLE:  ctrl.req_ready = 1'b1;
			S_STORE: ctrl.store_en = 1'b1;
			S_FETCH: begin
				ctrl.use_lvl_cnt = 1'b1;
				ctrl.fetch_rd    = (lvl_q <= LVL_W'(h_q));
			end
			S_DONE:  ctrl = '0;
			default: ctrl = '0;
		endcase
	end

	assign req.ready = ctrl.req_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tree_height_q <= HEIGHT_RESET;
			pmap_q        <= '0;
			valid_q       <= '0;
			rsp_valid_q   <= 1'b0;
			issued_s1     <= 1'b0;
			lvl_q         <= '0;
		end else begin
			state_q   <= state_d;
			issued_s1 <= ctrl.fetch_rd;
			if (cfg.valid) begin
				tree_height_q <= cfg.tree_height;
			end
			// Set leaf takes effect at accept
			if (req_fire && (cmd_t'(req.cmd) == CMD_SET_LEAF)) begin
				pmap_q[req.block_index[BLK_W-1:0]] <= req.leaf[MAP_W-1:0];
			end
			if (ctrl.store_en && !occupied) begin
				valid_q[bucket][slot_q] <= 1'b1;
			end
			// Walk counter: restart at the root, advance one level per read
			if (req_fire) begin
				lvl_q <= '0;
			end else if (ctrl.fetch_rd) begin
				lvl_q <= lvl_q + LVL_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload and result registers
	always_ff @(posedge clk) begin
		bucket_s1 <= bucket;
		last_s1   <= last_level;
		if (req_fire) begin
			cmd_q         <= req.cmd;
			blk_q         <= req.block_index[BLK_W-1:0];
			h_q           <= h_in;
			lv_q          <= lv_in;
			slot_q        <= req.slot[SLOT_W-1:0];
			pay_q         <= PAYLOAD_BITS'(req.payload);
			res_status_q  <= (cmd_t'(req.cmd) == CMD_FETCH) ? ST_NOT_FOUND : ST_OK;
			res_payload_q <= '0;
		end
		if (ctrl.store_en) begin
			res_status_q <= occupied ? ST_OCCUPIED : ST_OK;
		end
		if (state_q == S_FETCH && issued_s1 && hit) begin
			res_status_q  <= ST_OK;
			res_payload_q <= hit_payload;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_status_q  <= res_status_q;
			rsp_payload_q <= res_payload_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.payload_out = rsp_payload_q;

`ifndef SYNTHESIS
	// An accepted item always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q != S_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// A successful store leaves its slot marked valid
	a_store_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.store_en && !occupied) |=> valid_q[$past(bucket)][$past(slot_q)])
		else $error("stored slot not marked valid");

	// The walk never reads past the leaf level
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (lvl_q <= LVL_W'(h_q) + LVL_W'(1)))
		else $error("path walk ran past the leaf");

	// The store state is entered only for a store command
	a_store_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STORE) |-> (cmd_t'(cmd_q) == CMD_STORE))
		else $error("store state entered for another command");
`endif

endmodule

### design/tops_ram.sv
// ----------------------------------------------------------------------------
// tops_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tops_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/tops_path_unit.sv
// ----------------------------------------------------------------------------
// tops_path_unit
// Bucket address of one level on the path from a leaf to the root.
// ----------------------------------------------------------------------------
module tops_path_unit (
	input  logic [tops_pkg::HT_W-1:0]  height,
	input  logic [tops_pkg::MAP_W-1:0] leaf,
	input  logic [tops_pkg::HT_W-1:0]  level,
	output logic [tops_pkg::BKT_W-1:0] bucket
);
	import tops_pkg::*;

	logic [NODE_W-1:0] top_bit;
	logic [NODE_W-1:0] node;
	logic [NODE_W-1:0] shifted;
	logic [HT_W-1:0]   shamt;

	// node = 2^h + (leaf mod 2^h); bucket = (node >> (h - level)) - 1
	always_comb begin
		top_bit = NODE_W'(1) << height;
		node    = top_bit | ({1'b0, leaf} & (top_bit - NODE_W'(1)));
		shamt   = height - level;
		shifted = node >> shamt;
		bucket  = BKT_W'(shifted - NODE_W'(1));
	end

endmodule
